FILE: sv/swk_pkg.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics package
// Shared widths, fixed-point constants, arctangent table and structs.
// ----------------------------------------------------------------------------
package swk_pkg;

   localparam int ANGLE_FRAC_BITS   = 13;
   localparam int ANGLE_SHIFT       = 30 - ANGLE_FRAC_BITS;
   localparam int STEER_SHIFT       = 38 - ANGLE_FRAC_BITS;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;

   // Internal angle width (Q30 radians), rotation and vectoring datapaths.
   localparam int AW = 38;
   localparam int RW = 34;
   localparam int VW = 38;
   localparam int MW = 38;

   typedef logic signed [AW-1:0] angle_type;
   typedef logic signed [RW-1:0] rot_type;
   typedef logic signed [VW-1:0] vec_type;
   typedef logic signed [MW-1:0] mag_type;

   localparam angle_type PI_Q30         = 38'sd3373259426;
   localparam angle_type TWO_PI_Q30     = 38'sd6746518853;
   localparam angle_type HALF_PI_Q30    = 38'sd1686629713;
   localparam angle_type THREE_HALF_Q30 = 38'sd5059889139;
   localparam angle_type YAW_REF_Q30    = 38'sd1686633657;
   localparam angle_type UNWRAP_Q30     = 38'sd6743098655;
   localparam rot_type   GAIN_ROT       = 34'sd652032874;
   localparam logic signed [30:0] GAIN_MUL = 31'sd652032874;

   // Corners whose rotation term enters negated on x and on y.
   localparam logic [3:0] KX_NEG = 4'b0011;
   localparam logic [3:0] KY_NEG = 4'b1001;

   typedef enum logic [2:0] {
      CSR_HALF_LENGTH_X      = 3'd0,
      CSR_HALF_WIDTH_Y       = 3'd1,
      CSR_MAX_YAW_RATE       = 3'd2,
      CSR_MIN_DRIVE_SPEED    = 3'd3,
      CSR_STEER_RATIO        = 3'd4,
      CSR_MAX_STEER_POSITION = 3'd5,
      CSR_MAX_DRIVE_SPEED    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] half_length_x;
      logic [15:0] half_width_y;
      logic [14:0] max_yaw_rate;
      logic [11:0] min_drive_speed;
      logic [15:0] steer_ratio;
      logic [30:0] max_steer_position;
      logic [14:0] max_drive_speed;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] spd;
      logic signed [15:0] om;
      angle_type          dir;
      logic [3:0][15:0]   nows;
      logic               zero;
      logic               brake;
   } rot_side_type;

   typedef struct packed {
      logic [15:0] now;
      angle_type   dir;
      logic        zero;
   } lane_side_type;

   typedef struct packed {
      logic [3:0][31:0] pos;
      logic [3:0][15:0] drv;
      logic             brake;
   } rsp_type;

   function automatic angle_type atan_q30(input int idx);
      case (idx)
         0:  return 38'sd843314857;
         1:  return 38'sd497837829;
         2:  return 38'sd263043837;
         3:  return 38'sd133525159;
         4:  return 38'sd67021687;
         5:  return 38'sd33543516;
         6:  return 38'sd16775851;
         7:  return 38'sd8388437;
         8:  return 38'sd4194283;
         9:  return 38'sd2097149;
         10: return 38'sd1048576;
         11: return 38'sd524288;
         12: return 38'sd262144;
         13: return 38'sd131072;
         14: return 38'sd65536;
         15: return 38'sd32768;
         16: return 38'sd16384;
         17: return 38'sd8192;
         18: return 38'sd4096;
         19: return 38'sd2048;
         20: return 38'sd1024;
         21: return 38'sd512;
         22: return 38'sd256;
         23: return 38'sd128;
         default: return 38'sd0;
      endcase
   endfunction

   function automatic angle_type angle_in(input logic signed [15:0] raw);
      return angle_type'(raw) <<< ANGLE_SHIFT;
   endfunction

endpackage

FILE: sv/swk_req_if.sv
// ----------------------------------------------------------------------------
// Swerve command channel
// Valid/ready channel carrying one chassis command word.
// ----------------------------------------------------------------------------
interface swk_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] speed;
   logic signed [15:0] heading;
   logic signed [15:0] yaw_rate;
   logic               field_relative;
   logic signed [15:0] measured_yaw;
   logic               handbrake;
   logic signed [15:0] angle_now_a;
   logic signed [15:0] angle_now_b;
   logic signed [15:0] angle_now_c;
   logic signed [15:0] angle_now_d;

   modport source (output valid, speed, heading, yaw_rate, field_relative, measured_yaw,
                   handbrake, angle_now_a, angle_now_b, angle_now_c, angle_now_d,
                   input ready);
   modport sink (input valid, speed, heading, yaw_rate, field_relative, measured_yaw,
                 handbrake, angle_now_a, angle_now_b, angle_now_c, angle_now_d,
                 output ready);
endinterface

FILE: sv/swk_rsp_if.sv
// ----------------------------------------------------------------------------
// Swerve wheel result channel
// Valid/ready channel carrying steer targets, drive speeds and brake.
// ----------------------------------------------------------------------------
interface swk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] steer_pos_a;
   logic signed [31:0] steer_pos_b;
   logic signed [31:0] steer_pos_c;
   logic signed [31:0] steer_pos_d;
   logic signed [15:0] drive_a;
   logic signed [15:0] drive_b;
   logic signed [15:0] drive_c;
   logic signed [15:0] drive_d;
   logic               brake_out;

   modport source (output valid, steer_pos_a, steer_pos_b, steer_pos_c, steer_pos_d,
                   drive_a, drive_b, drive_c, drive_d, brake_out, input ready);
   modport sink (input valid, steer_pos_a, steer_pos_b, steer_pos_c, steer_pos_d,
                 drive_a, drive_b, drive_c, drive_d, brake_out, output ready);
endinterface

FILE: sv/swk_csr_if.sv
// ----------------------------------------------------------------------------
// Swerve configuration write channel
// Valid/ready register write with index and data.
// ----------------------------------------------------------------------------
interface swk_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/swk_rot.sv
// ----------------------------------------------------------------------------
// Swerve rotation CORDIC
// Pipelined cos/sin of the chassis heading, one iteration per stage.
// ----------------------------------------------------------------------------
module swk_rot #(
   parameter int STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  swk_pkg::angle_type    ang,
   input  logic                  neg,
   input  swk_pkg::rot_side_type side,
   output swk_pkg::rot_type      cos_q,
   output swk_pkg::rot_type      sin_q,
   output swk_pkg::rot_side_type side_q
);

   swk_pkg::rot_type      x_ff    [STAGES];
   swk_pkg::rot_type      y_ff    [STAGES];
   swk_pkg::angle_type    a_ff    [STAGES];
   logic                  neg_ff  [STAGES];
   swk_pkg::rot_side_type side_ff [STAGES];

   genvar i;
   for (i = 0; i < STAGES; i++) begin : g_stage
      swk_pkg::rot_type      x_prev, y_prev, x_in, y_in;
      swk_pkg::angle_type    a_prev, a_in;
      logic                  neg_prev;
      swk_pkg::rot_side_type side_prev;

      if (i == 0) begin : g_first
         assign x_prev    = swk_pkg::GAIN_ROT;
         assign y_prev    = '0;
         assign a_prev    = ang;
         assign neg_prev  = neg;
         assign side_prev = side;
      end else begin : g_next
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign a_prev    = a_ff[i-1];
         assign neg_prev  = neg_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         if (a_prev >= 0) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            a_in = a_prev - swk_pkg::atan_q30(i);
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            a_in = a_prev + swk_pkg::atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            a_ff[i]    <= a_in;
            neg_ff[i]  <= neg_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   // The half-plane fold ahead of the pipeline is undone here.
   assign cos_q  = neg_ff[STAGES-1] ? -x_ff[STAGES-1] : x_ff[STAGES-1];
   assign sin_q  = neg_ff[STAGES-1] ? -y_ff[STAGES-1] : y_ff[STAGES-1];
   assign side_q = side_ff[STAGES-1];

endmodule

FILE: sv/swk_lane.sv
// ----------------------------------------------------------------------------
// Swerve wheel lane
// Vectoring CORDIC, magnitude gain, minor-arc rule and output scaling
// for one wheel.
// ----------------------------------------------------------------------------
module swk_lane #(
   parameter int STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic                   en,
   input  swk_pkg::vec_type       sx,
   input  swk_pkg::vec_type       sy,
   input  swk_pkg::lane_side_type side,
   input  swk_pkg::cfg_type       cfg,
   output logic signed [31:0]     pos,
   output logic signed [15:0]     drv
);

   localparam int HW  = swk_pkg::VW - 16;
   localparam int PHW = HW + 31;
   localparam int PLW = 17 + 31;
   localparam int SW  = PHW + 16;
   localparam int PW  = swk_pkg::AW + 17;
   localparam int DW  = 24;

   localparam logic signed [SW-1:0] RND30 = SW'(64'sd536870912);
   localparam logic signed [PW-1:0] RND25 = PW'(64'sd1) <<< (swk_pkg::STEER_SHIFT - 1);
   localparam swk_pkg::mag_type     RND16 = swk_pkg::MW'(64'sd32768);

   // ---- pre-rotation into the right half plane
   swk_pkg::vec_type       px_in, py_in, px_ff, py_ff;
   swk_pkg::angle_type     pz_in, pz_ff;
   logic                   pzv_in, pzv_ff;
   swk_pkg::lane_side_type pside_ff;

   always_comb begin
      pzv_in = (sx == '0) && (sy == '0);
      if (sx < 0) begin
         pz_in = (sy >= 0) ? swk_pkg::PI_Q30 : -swk_pkg::PI_Q30;
         px_in = -sx;
         py_in = -sy;
      end else begin
         pz_in = '0;
         px_in = sx;
         py_in = sy;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         pzv_ff   <= pzv_in;
         pside_ff <= side;
      end
   end

   // ---- vectoring iterations
   swk_pkg::vec_type       x_ff    [STAGES];
   swk_pkg::vec_type       y_ff    [STAGES];
   swk_pkg::angle_type     z_ff    [STAGES];
   logic                   zv_ff   [STAGES];
   swk_pkg::lane_side_type side_ff [STAGES];

   genvar i;
   for (i = 0; i < STAGES; i++) begin : g_stage
      swk_pkg::vec_type       x_prev, y_prev, x_in, y_in;
      swk_pkg::angle_type     z_prev, z_in;
      logic                   zv_prev;
      swk_pkg::lane_side_type side_prev;

      if (i == 0) begin : g_first
         assign x_prev    = px_ff;
         assign y_prev    = py_ff;
         assign z_prev    = pz_ff;
         assign zv_prev   = pzv_ff;
         assign side_prev = pside_ff;
      end else begin : g_next
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign zv_prev   = zv_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         if (y_prev > 0) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + swk_pkg::atan_q30(i);
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - swk_pkg::atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            zv_ff[i]   <= zv_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   // ---- stage 1: gain products, target angle and difference to current
   logic signed [PHW-1:0]  phi_in, phi_ff;
   logic signed [PLW-1:0]  plo_in, plo_ff;
   swk_pkg::angle_type     tgt_in, tgt1_ff, now_in, now1_ff, d_in, d_ff;
   logic                   zero1_ff;
   swk_pkg::vec_type       xl;

   always_comb begin
      xl     = x_ff[STAGES-1];
      phi_in = PHW'($signed(xl[swk_pkg::VW-1:16])) * PHW'(swk_pkg::GAIN_MUL);
      plo_in = PLW'($signed({1'b0, xl[15:0]})) * PLW'(swk_pkg::GAIN_MUL);
      if (side_ff[STAGES-1].zero) begin
         tgt_in = side_ff[STAGES-1].dir;
      end else if (zv_ff[STAGES-1]) begin
         tgt_in = '0;
      end else begin
         tgt_in = z_ff[STAGES-1];
      end
      now_in = swk_pkg::angle_in(side_ff[STAGES-1].now);
      d_in   = tgt_in - now_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff   <= phi_in;
         plo_ff   <= plo_in;
         tgt1_ff  <= tgt_in;
         now1_ff  <= now_in;
         d_ff     <= d_in;
         zero1_ff <= side_ff[STAGES-1].zero;
      end
   end

   // ---- stage 2: magnitude, minor-arc decision
   swk_pkg::mag_type   mag_in, mag2_ff;
   swk_pkg::angle_type ad, dadj_in, dadj_ff, tgt2_ff, now2_ff;
   logic               flip_in, flip_ff, zero2_ff;
   logic signed [SW-1:0] msum;

   always_comb begin
      msum    = (SW'(phi_ff) <<< 16) + SW'(plo_ff) + RND30;
      mag_in  = swk_pkg::MW'(msum >>> 30);
      ad      = (d_ff < 0) ? -d_ff : d_ff;
      flip_in = (ad > swk_pkg::HALF_PI_Q30) && (ad < swk_pkg::THREE_HALF_Q30);
      if (d_ff > swk_pkg::THREE_HALF_Q30) begin
         dadj_in = d_ff - swk_pkg::UNWRAP_Q30;
      end else if (d_ff < -swk_pkg::THREE_HALF_Q30) begin
         dadj_in = d_ff + swk_pkg::UNWRAP_Q30;
      end else begin
         dadj_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff  <= mag_in;
         dadj_ff  <= dadj_in;
         flip_ff  <= flip_in;
         tgt2_ff  <= tgt1_ff;
         now2_ff  <= now1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // ---- stage 3: apply the minor-arc rule
   swk_pkg::angle_type ang_in, ang_ff;
   swk_pkg::mag_type   magv_in, magv_ff;
   logic               zero3_ff;

   always_comb begin
      if (flip_ff) begin
         ang_in  = (tgt2_ff < 0) ? tgt2_ff + swk_pkg::PI_Q30 : tgt2_ff - swk_pkg::PI_Q30;
         magv_in = -mag2_ff;
      end else begin
         ang_in  = now2_ff + dadj_ff;
         magv_in = mag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff   <= ang_in;
         magv_ff  <= magv_in;
         zero3_ff <= zero2_ff;
      end
   end

   // ---- stage 4: steer ratio product, start-up offset
   logic signed [PW-1:0] prod_in, prod_ff;
   swk_pkg::mag_type     off16, moff_in, moff_ff;
   logic                 zero4_ff;

   always_comb begin
      prod_in = PW'(ang_ff) * PW'($signed({1'b0, cfg.steer_ratio}));
      off16   = swk_pkg::MW'({cfg.min_drive_speed, 16'h0000});
      moff_in = (magv_ff > 0) ? magv_ff + off16 : magv_ff - off16;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         moff_ff  <= moff_in;
         zero4_ff <= zero3_ff;
      end
   end

   // ---- stage 5: round and clamp
   logic signed [31:0]   pr, ms, pos_in, pos_ff;
   logic signed [DW-1:0] dr, md;
   logic signed [15:0]   drv_in, drv_ff;

   always_comb begin
      pr = 32'((prod_ff + RND25) >>> swk_pkg::STEER_SHIFT);
      ms = $signed({1'b0, cfg.max_steer_position});
      if (pr > ms) begin
         pos_in = ms;
      end else if (pr < -ms) begin
         pos_in = -ms;
      end else begin
         pos_in = pr;
      end
      dr = DW'((moff_ff + RND16) >>> 16);
      md = DW'($signed({1'b0, cfg.max_drive_speed}));
      if (zero4_ff) begin
         drv_in = '0;
      end else if (dr > md) begin
         drv_in = 16'(md);
      end else if (dr < -md) begin
         drv_in = 16'(-md);
      end else begin
         drv_in = 16'(dr);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff <= pos_in;
         drv_ff <= drv_in;
      end
   end

   assign pos = pos_ff;
   assign drv = drv_ff;

endmodule

FILE: sv/swerve_wheel_kinematics_unit.sv
// ----------------------------------------------------------------------------
// Swerve wheel kinematics unit
// Chassis command to four steer targets and drive speeds.
// ----------------------------------------------------------------------------
// The unit takes one chassis command word per clock while it is not stalled
// and returns one result word per command, in order. The rotation CORDIC and
// the four per-wheel vectoring CORDICs are fully pipelined, one iteration per
// stage, so throughput is one word per cycle. A two-word output queue lets
// commands keep flowing while a result waits; the pipeline stalls only when
// both queue slots are full and the result side is not ready. Configuration
// writes take effect at once and should be made while the pipeline is empty.
module swerve_wheel_kinematics_unit #(
   parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
   input logic   clock,
   input logic   reset,
   swk_req_if.sink   req_bus,
   swk_rsp_if.source rsp_bus,
   swk_csr_if.sink   csr_bus
);

   localparam int LANE_LAT = CORDIC_STAGES + 6;
   localparam int LAT      = 2 * CORDIC_STAGES + 15;
   localparam int PVW      = 16 + swk_pkg::RW;
   localparam int PTW      = 33;

   localparam logic signed [PVW-1:0] RND14 = PVW'(64'sd8192);
   localparam logic signed [PTW-1:0] RND4  = PTW'(64'sd8);

   typedef struct packed {
      logic signed [15:0] spd;
      logic signed [15:0] om;
      swk_pkg::angle_type dir;
      swk_pkg::angle_type off;
      swk_pkg::angle_type a;
      logic               neg;
      logic               zero;
      logic               brake;
      logic [3:0][15:0]   nows;
   } front_type;

   // ---- configuration registers
   swk_pkg::cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_length_x      <= 16'd256;
         cfg_ff.half_width_y       <= 16'd256;
         cfg_ff.max_yaw_rate       <= 15'd16384;
         cfg_ff.min_drive_speed    <= 12'd0;
         cfg_ff.steer_ratio        <= 16'd256;
         cfg_ff.max_steer_position <= 31'h7FFF_FFFF;
         cfg_ff.max_drive_speed    <= 15'd32767;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            swk_pkg::CSR_HALF_LENGTH_X:      cfg_ff.half_length_x      <= csr_bus.data[15:0];
            swk_pkg::CSR_HALF_WIDTH_Y:       cfg_ff.half_width_y       <= csr_bus.data[15:0];
            swk_pkg::CSR_MAX_YAW_RATE:       cfg_ff.max_yaw_rate       <= csr_bus.data[14:0];
            swk_pkg::CSR_MIN_DRIVE_SPEED:    cfg_ff.min_drive_speed    <= csr_bus.data[11:0];
            swk_pkg::CSR_STEER_RATIO:        cfg_ff.steer_ratio        <= csr_bus.data[15:0];
            swk_pkg::CSR_MAX_STEER_POSITION: cfg_ff.max_steer_position <= csr_bus.data[30:0];
            swk_pkg::CSR_MAX_DRIVE_SPEED:    cfg_ff.max_drive_speed    <= csr_bus.data[14:0];
            default: ;
         endcase
      end
   end

   // ---- flow control
   logic                  adv;
   logic [1:0]            cnt_ff, cnt_in;
   logic [LAT-1:0]        vld_ff;
   swk_pkg::rsp_type      q_ff [2];
   swk_pkg::rsp_type      q_in [2];
   swk_pkg::rsp_type      res_ff, res_in;
   logic                  push, pop;
   logic                  widx;

   assign adv           = (cnt_ff != 2'd2) || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
      end
   end

   // ---- front end: yaw clamp, field-relative heading, angle reduction
   front_type f1_in, f1_ff, f2_in, f2_ff, f3_in, f3_ff;
   front_type f4_in, f4_ff, f5_in, f5_ff, f6_in, f6_ff;
   logic signed [16:0] yaw_x, ym_pos;

   always_comb begin
      yaw_x  = 17'(req_bus.yaw_rate);
      ym_pos = $signed({2'b00, cfg_ff.max_yaw_rate});
      f1_in  = '0;
      f1_in.spd = req_bus.speed;
      if (yaw_x > ym_pos) begin
         f1_in.om = 16'(ym_pos);
      end else if (yaw_x < -ym_pos) begin
         f1_in.om = 16'(-ym_pos);
      end else begin
         f1_in.om = req_bus.yaw_rate;
      end
      f1_in.dir  = swk_pkg::angle_in(req_bus.heading);
      f1_in.off  = req_bus.field_relative ?
                   swk_pkg::angle_in(req_bus.measured_yaw) - swk_pkg::YAW_REF_Q30 : '0;
      f1_in.zero = (req_bus.speed == '0) && (f1_in.om == '0);
      f1_in.brake   = req_bus.handbrake;
      f1_in.nows[0] = req_bus.angle_now_a;
      f1_in.nows[1] = req_bus.angle_now_b;
      f1_in.nows[2] = req_bus.angle_now_c;
      f1_in.nows[3] = req_bus.angle_now_d;
   end

   always_comb begin
      // Yaw offset is brought down by one turn only when above pi.
      f2_in = f1_ff;
      if (f1_ff.off > swk_pkg::PI_Q30) begin
         f2_in.off = f1_ff.off - swk_pkg::TWO_PI_Q30;
      end

      f3_in     = f2_ff;
      f3_in.dir = f2_ff.dir - f2_ff.off;
      f3_in.a   = f2_ff.dir - f2_ff.off;

      // Truncating remainder by one turn; the range allows at most one step.
      f4_in = f3_ff;
      if (f3_ff.a >= swk_pkg::TWO_PI_Q30) begin
         f4_in.a = f3_ff.a - swk_pkg::TWO_PI_Q30;
      end else if (f3_ff.a <= -swk_pkg::TWO_PI_Q30) begin
         f4_in.a = f3_ff.a + swk_pkg::TWO_PI_Q30;
      end

      f5_in = f4_ff;
      if (f4_ff.a > swk_pkg::PI_Q30) begin
         f5_in.a = f4_ff.a - swk_pkg::TWO_PI_Q30;
      end else if (f4_ff.a < -swk_pkg::PI_Q30) begin
         f5_in.a = f4_ff.a + swk_pkg::TWO_PI_Q30;
      end

      f6_in = f5_ff;
      if (f5_ff.a > swk_pkg::HALF_PI_Q30) begin
         f6_in.a   = f5_ff.a - swk_pkg::PI_Q30;
         f6_in.neg = 1'b1;
      end else if (f5_ff.a < -swk_pkg::HALF_PI_Q30) begin
         f6_in.a   = f5_ff.a + swk_pkg::PI_Q30;
         f6_in.neg = 1'b1;
      end else begin
         f6_in.neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
         f5_ff <= f5_in;
         f6_ff <= f6_in;
      end
   end

   // ---- heading rotation
   swk_pkg::rot_side_type rside, rside_q;
   swk_pkg::rot_type      cos_q, sin_q;

   always_comb begin
      rside.spd   = f6_ff.spd;
      rside.om    = f6_ff.om;
      rside.dir   = f6_ff.dir;
      rside.nows  = f6_ff.nows;
      rside.zero  = f6_ff.zero;
      rside.brake = f6_ff.brake;
   end

   swk_rot #(
      .STAGES (CORDIC_STAGES)
   ) u_rot (
      .clock  (clock),
      .en     (adv),
      .ang    (f6_ff.a),
      .neg    (f6_ff.neg),
      .side   (rside),
      .cos_q  (cos_q),
      .sin_q  (sin_q),
      .side_q (rside_q)
   );

   // ---- translation and rotation terms, corner sums
   logic signed [PVW-1:0] pvx_in, pvx_ff, pvy_in, pvy_ff;
   logic signed [PTW-1:0] ptx_in, ptx_ff, pty_in, pty_ff;
   swk_pkg::rot_side_type m1side_ff, m2side_ff;
   swk_pkg::vec_type      vx, vy, tx, ty;
   swk_pkg::vec_type      sx_in [4];
   swk_pkg::vec_type      sy_in [4];
   swk_pkg::vec_type      sx_ff [4];
   swk_pkg::vec_type      sy_ff [4];

   always_comb begin
      pvx_in = PVW'(rside_q.spd) * PVW'(cos_q);
      pvy_in = PVW'(rside_q.spd) * PVW'(sin_q);
      ptx_in = PTW'(rside_q.om) * PTW'($signed({1'b0, cfg_ff.half_length_x}));
      pty_in = PTW'(rside_q.om) * PTW'($signed({1'b0, cfg_ff.half_width_y}));
   end

   always_comb begin
      vx = swk_pkg::VW'((pvx_ff + RND14) >>> 14);
      vy = swk_pkg::VW'((pvy_ff + RND14) >>> 14);
      tx = swk_pkg::VW'((ptx_ff + RND4) >>> 4);
      ty = swk_pkg::VW'((pty_ff + RND4) >>> 4);
      for (int w = 0; w < 4; w++) begin
         sx_in[w] = swk_pkg::KX_NEG[w] ? vx - tx : vx + tx;
         sy_in[w] = swk_pkg::KY_NEG[w] ? vy - ty : vy + ty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pvx_ff    <= pvx_in;
         pvy_ff    <= pvy_in;
         ptx_ff    <= ptx_in;
         pty_ff    <= pty_in;
         m1side_ff <= rside_q;
         m2side_ff <= m1side_ff;
         for (int w = 0; w < 4; w++) begin
            sx_ff[w] <= sx_in[w];
            sy_ff[w] <= sy_in[w];
         end
      end
   end

   // ---- wheel lanes
   logic signed [31:0] pos_w [4];
   logic signed [15:0] drv_w [4];

   genvar gw;
   for (gw = 0; gw < 4; gw++) begin : g_lane
      swk_pkg::lane_side_type lside;

      assign lside.now  = m2side_ff.nows[gw];
      assign lside.dir  = m2side_ff.dir;
      assign lside.zero = m2side_ff.zero;

      swk_lane #(
         .STAGES (CORDIC_STAGES)
      ) u_lane (
         .clock (clock),
         .en    (adv),
         .sx    (sx_ff[gw]),
         .sy    (sy_ff[gw]),
         .side  (lside),
         .cfg   (cfg_ff),
         .pos   (pos_w[gw]),
         .drv   (drv_w[gw])
      );
   end

   // Handbrake rides alongside the lanes.
   logic brk_ff [LANE_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         brk_ff[0] <= m2side_ff.brake;
         for (int k = 1; k < LANE_LAT; k++) begin
            brk_ff[k] <= brk_ff[k-1];
         end
      end
   end

   // ---- merge the four wheels into one result word
   always_comb begin
      res_in.brake = brk_ff[LANE_LAT-1];
      for (int w = 0; w < 4; w++) begin
         res_in.pos[w] = pos_w[w];
         res_in.drv[w] = brk_ff[LANE_LAT-1] ? 16'h0000 : drv_w[w];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   // ---- two-word output queue
   assign push = adv && vld_ff[LAT-1];
   assign pop  = (cnt_ff != 2'd0) && rsp_bus.ready;
   assign widx = 1'(cnt_ff - {1'b0, pop});

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         q_in[widx] = res_ff;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_bus.valid       = (cnt_ff != 2'd0);
   assign rsp_bus.steer_pos_a = q_ff[0].pos[0];
   assign rsp_bus.steer_pos_b = q_ff[0].pos[1];
   assign rsp_bus.steer_pos_c = q_ff[0].pos[2];
   assign rsp_bus.steer_pos_d = q_ff[0].pos[3];
   assign rsp_bus.drive_a     = q_ff[0].drv[0];
   assign rsp_bus.drive_b     = q_ff[0].drv[1];
   assign rsp_bus.drive_c     = q_ff[0].drv[2];
   assign rsp_bus.drive_d     = q_ff[0].drv[3];
   assign rsp_bus.brake_out   = q_ff[0].brake;

endmodule
